// ===== design/utcts_pkg.sv =====
// Shared types, constants and lookup functions for the UTC timestamp converter.
`timescale 1ns / 1ps
`default_nettype none

package utcts_pkg;

    localparam int unsigned TextLen   = 20;
    localparam int unsigned PosMax    = 31;
    localparam int unsigned PosWidth  = 5;
    localparam int unsigned YearWidth = 14;
    localparam int unsigned FieldWidth = 7;
    localparam int unsigned SecsWidth = 34;
    localparam int unsigned DaysWidth = 17;
    localparam int unsigned DoeWidth  = 18;

    localparam int unsigned YearMin    = 1970;
    localparam int unsigned YearMax    = 2261;
    localparam int unsigned EraYears   = 400;
    localparam int unsigned EraDays    = 146097;
    localparam int unsigned EpochShift = 719468;
    localparam int unsigned SecsPerDay = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin = 60;
    localparam int unsigned DaysPerYear = 365;

    // Every valid date falls in era 4 or era 5 of the proleptic calendar.
    localparam int unsigned Era5Start  = 5 * EraYears;
    localparam int unsigned Era4Start  = 4 * EraYears;
    localparam int unsigned Era5Offset = 5 * EraDays - EpochShift;
    localparam int unsigned Era4Offset = EpochShift - 4 * EraDays;

    localparam logic [7:0] CharDash  = 8'h2D;
    localparam logic [7:0] CharT     = 8'h54;
    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharZ     = 8'h5A;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharNone  = 8'h00;

    typedef struct packed {
        logic take_char;
        logic take_last;
        logic step_date;
        logic step_doe;
        logic step_days;
        logic step_mul;
        logic emit;
    } utcts_cmd_t;

    // Separator expected at a text position, or CharNone where a digit belongs.
    function automatic logic [7:0] sep_at(input logic [PosWidth-1:0] pos);
        logic [7:0] s;
        begin
            unique case (pos)
                5'd4, 5'd7:   s = CharDash;
                5'd10:        s = CharT;
                5'd13, 5'd16: s = CharColon;
                5'd19:        s = CharZ;
                default:      s = CharNone;
            endcase
            return s;
        end
    endfunction

    // Days in a month of a common year; month codes outside 1..12 are never used.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] d;
        begin
            unique case (month)
                4'd2:                      d = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                default:                   d = 5'd31;
            endcase
            return d;
        end
    endfunction

    // Day of the March-based year on which shifted month mp starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        begin
            unique case (mp)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd61;
                4'd3:    d = 9'd92;
                4'd4:    d = 9'd122;
                4'd5:    d = 9'd153;
                4'd6:    d = 9'd184;
                4'd7:    d = 9'd214;
                4'd8:    d = 9'd245;
                4'd9:    d = 9'd275;
                4'd10:   d = 9'd306;
                default: d = 9'd337;
            endcase
            return d;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/utc_timestamp_to_epoch_seconds.sv =====
// Top level of the strict UTC timestamp to Unix seconds converter.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   input   | in_valid, in_ready, ch, last            | in
//   output  | out_valid, out_ready, valid_res,        | out
//           | epoch_seconds                           |
//
// A character that is not final is taken while idle; the final character starts a
// five-step conversion (date split, day of era, day count, multiply by 86400,
// final add).
// Reset clears the position counter, the checks and the output valid flag.
// A finished transaction waits in the output register; the next text is taken
// only after its result has moved into that register.
`timescale 1ns / 1ps
`default_nettype none

module utc_timestamp_to_epoch_seconds
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         ch,
    input  wire logic                               last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    valid_res,
    output logic [utcts_pkg::SecsWidth-1:0]         epoch_seconds
);
    import utcts_pkg::*;

    utcts_cmd_t cmd;

    utcts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    utcts_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .ch            (ch),
        .valid_res     (valid_res),
        .epoch_seconds (epoch_seconds)
    );

endmodule

`default_nettype wire

// ===== design/utcts_ctrl.sv =====
// Controller state machine sequencing character intake and the date conversion steps.
`timescale 1ns / 1ps
`default_nettype none

module utcts_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  last,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output utcts_pkg::utcts_cmd_t      cmd
);
    import utcts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DATE,
        S_DOE,
        S_DAYS,
        S_MUL,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   take;
    logic   emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && in_ready;
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.take_char = take;
        cmd.take_last = take && last;
        cmd.step_date = (state_reg == S_DATE);
        cmd.step_doe  = (state_reg == S_DOE);
        cmd.step_days = (state_reg == S_DAYS);
        cmd.step_mul  = (state_reg == S_MUL);
        cmd.emit      = emit;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && last)
                begin
                    state_next = S_DATE;
                end
            end
            S_DATE:  state_next = S_DOE;
            S_DOE:   state_next = S_DAYS;
            S_DAYS:  state_next = S_MUL;
            S_MUL:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/utcts_dp.sv =====
// Datapath: character checks, digit accumulators and the days-from-civil arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module utcts_dp
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire utcts_pkg::utcts_cmd_t                cmd,
    input  wire logic [7:0]                           ch,
    output logic                                      valid_res,
    output logic [utcts_pkg::SecsWidth-1:0]           epoch_seconds
);
    import utcts_pkg::*;

    // Character intake state.
    logic [PosWidth-1:0]   pos_reg;
    logic [PosWidth-1:0]   pos_next;
    logic                  pattern_ok_reg;
    logic                  pattern_ok_next;
    logic [YearWidth-1:0]  year_reg;
    logic [YearWidth-1:0]  year_next;
    logic [FieldWidth-1:0] month_reg;
    logic [FieldWidth-1:0] month_next;
    logic [FieldWidth-1:0] day_reg;
    logic [FieldWidth-1:0] day_next;
    logic [FieldWidth-1:0] hour_reg;
    logic [FieldWidth-1:0] hour_next;
    logic [FieldWidth-1:0] minute_reg;
    logic [FieldWidth-1:0] minute_next;
    logic [FieldWidth-1:0] second_reg;
    logic [FieldWidth-1:0] second_next;

    logic [7:0]            sep;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  in_text;
    logic                  digit_ok;
    logic                  leap;
    logic [4:0]            dim;
    logic                  range_ok;
    logic                  final_ok;

    // Conversion pipeline registers.
    logic                  ok_reg;
    logic [YearWidth-1:0]  yp_reg;
    logic [3:0]            mp_reg;
    logic [4:0]            dday_reg;
    logic [4:0]            hh_reg;
    logic [5:0]            mm_reg;
    logic [5:0]            ss_reg;
    logic                  era5_reg;
    logic [8:0]            yoe_reg;
    logic [8:0]            doy_reg;
    logic [DaysWidth-1:0]  hms_reg;
    logic [DoeWidth-1:0]   doe_reg;
    logic [DaysWidth-1:0]  days_reg;
    logic [SecsWidth-1:0]  prod_reg;
    logic                  valid_res_reg;
    logic [SecsWidth-1:0]  epoch_reg;

    logic                  era5;
    logic [YearWidth-1:0]  yoe_full;
    logic [1:0]            cent;
    logic [DoeWidth-1:0]   doe_calc;
    logic [DoeWidth-1:0]   days_calc;
    logic [SecsWidth-1:0]  sum_calc;

    assign sep      = sep_at(pos_reg);
    assign is_digit = (ch >= CharZero) && (ch <= CharNine);
    assign digit    = ch[3:0];
    assign in_text  = (pos_reg < PosWidth'(TextLen));
    assign digit_ok = in_text && (sep == CharNone) && is_digit;

    always_comb
    begin
        pattern_ok_next = pattern_ok_reg;
        if (!in_text)
        begin
            pattern_ok_next = 1'b0;
        end
        else if (sep != CharNone)
        begin
            if (ch != sep)
            begin
                pattern_ok_next = 1'b0;
            end
        end
        else if (!is_digit)
        begin
            pattern_ok_next = 1'b0;
        end
    end

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (digit_ok)
        begin
            priority if (pos_reg < 5'd4)
            begin
                year_next = YearWidth'({year_reg, 3'b000}) + YearWidth'({year_reg, 1'b0})
                          + YearWidth'(digit);
            end
            else if (pos_reg < 5'd7)
            begin
                month_next = FieldWidth'({month_reg, 3'b000})
                           + FieldWidth'({month_reg, 1'b0}) + FieldWidth'(digit);
            end
            else if (pos_reg < 5'd10)
            begin
                day_next = FieldWidth'({day_reg, 3'b000}) + FieldWidth'({day_reg, 1'b0})
                         + FieldWidth'(digit);
            end
            else if (pos_reg < 5'd13)
            begin
                hour_next = FieldWidth'({hour_reg, 3'b000}) + FieldWidth'({hour_reg, 1'b0})
                          + FieldWidth'(digit);
            end
            else if (pos_reg < 5'd16)
            begin
                minute_next = FieldWidth'({minute_reg, 3'b000})
                            + FieldWidth'({minute_reg, 1'b0}) + FieldWidth'(digit);
            end
            else
            begin
                second_next = FieldWidth'({second_reg, 3'b000})
                            + FieldWidth'({second_reg, 1'b0}) + FieldWidth'(digit);
            end
        end
    end

    always_comb
    begin
        if (cmd.take_last)
        begin
            pos_next = '0;
        end
        else if (pos_reg < PosWidth'(PosMax))
        begin
            pos_next = pos_reg + 5'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // The leap test is only consulted for years already known to be in range.
    assign leap = (year_reg[1:0] == 2'b00) && (year_reg != 14'd2100) && (year_reg != 14'd2200);
    assign dim  = ((month_reg == 7'd2) && leap) ? 5'd29 : month_len(month_reg[3:0]);

    assign range_ok = (year_reg >= YearWidth'(YearMin)) && (year_reg <= YearWidth'(YearMax))
                   && (month_reg >= 7'd1) && (month_reg <= 7'd12) && (day_reg >= 7'd1)
                   && (day_reg <= {2'b00, dim}) && (hour_reg <= 7'd23)
                   && (minute_reg <= 7'd59) && (second_reg <= 7'd59);
    assign final_ok = pattern_ok_next && (pos_reg == PosWidth'(TextLen - 1)) && range_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pattern_ok_reg <= 1'b1;
            year_reg       <= '0;
            month_reg      <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            ok_reg         <= 1'b0;
        end
        else if (cmd.take_last)
        begin
            pos_reg        <= '0;
            pattern_ok_reg <= 1'b1;
            year_reg       <= '0;
            month_reg      <= '0;
            day_reg        <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            second_reg     <= '0;
            ok_reg         <= final_ok;
        end
        else if (cmd.take_char)
        begin
            pos_reg        <= pos_next;
            pattern_ok_reg <= pattern_ok_next;
            year_reg       <= year_next;
            month_reg      <= month_next;
            day_reg        <= day_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
        end
    end

    // Snapshot of the fields; only meaningful when the text passed every check.
    always_ff @(posedge clk)
    begin
        if (cmd.take_last)
        begin
            yp_reg   <= (month_reg <= 7'd2) ? (year_reg - 14'd1) : year_reg;
            mp_reg   <= (month_reg > 7'd2) ? 4'(month_reg - 7'd3) : 4'(month_reg + 7'd9);
            dday_reg <= day_reg[4:0];
            hh_reg   <= hour_reg[4:0];
            mm_reg   <= minute_reg[5:0];
            ss_reg   <= second_reg[5:0];
        end
    end

    assign era5     = (yp_reg >= YearWidth'(Era5Start));
    assign yoe_full = yp_reg - (era5 ? YearWidth'(Era5Start) : YearWidth'(Era4Start));

    always_ff @(posedge clk)
    begin
        if (cmd.step_date)
        begin
            era5_reg <= era5;
            yoe_reg  <= yoe_full[8:0];
            doy_reg  <= month_start(mp_reg) + 9'(dday_reg) - 9'd1;
            hms_reg  <= DaysWidth'(hh_reg) * DaysWidth'(SecsPerHour)
                      + DaysWidth'(mm_reg) * DaysWidth'(SecsPerMin) + DaysWidth'(ss_reg);
        end
    end

    always_comb
    begin
        priority if (yoe_reg >= 9'd300)
        begin
            cent = 2'd3;
        end
        else if (yoe_reg >= 9'd200)
        begin
            cent = 2'd2;
        end
        else if (yoe_reg >= 9'd100)
        begin
            cent = 2'd1;
        end
        else
        begin
            cent = 2'd0;
        end
    end

    assign doe_calc = DoeWidth'(yoe_reg) * DoeWidth'(DaysPerYear) + DoeWidth'(yoe_reg[8:2])
                    - DoeWidth'(cent) + DoeWidth'(doy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.step_doe)
        begin
            doe_reg <= doe_calc;
        end
    end

    assign days_calc = era5_reg ? (doe_reg + DoeWidth'(Era5Offset))
                                : (doe_reg - DoeWidth'(Era4Offset));

    always_ff @(posedge clk)
    begin
        if (cmd.step_days)
        begin
            days_reg <= days_calc[DaysWidth-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step_mul)
        begin
            prod_reg <= SecsWidth'(days_reg) * SecsWidth'(SecsPerDay);
        end
    end

    assign sum_calc = prod_reg + SecsWidth'(hms_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            valid_res_reg <= ok_reg;
            epoch_reg     <= ok_reg ? sum_calc : '0;
        end
    end

    assign valid_res     = valid_res_reg;
    assign epoch_seconds = epoch_reg;

endmodule

`default_nettype wire

// ===== test/tb_utc_timestamp_to_epoch_seconds.sv =====
// Self-checking testbench for the strict UTC timestamp to Unix seconds converter.
`timescale 1ns / 1ps
`default_nettype none

module tb_utc_timestamp_to_epoch_seconds;
    import utcts_pkg::*;

    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned TargetChars = 850;
    localparam int unsigned TargetTexts = 40;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct {
        logic                 ok;
        logic [SecsWidth-1:0] secs;
    } epoch_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           ch = 8'h00;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 valid_res;
    logic [SecsWidth-1:0] epoch_seconds;

    text_char_t    char_q[$];
    epoch_result_t pending_epochs[$];
    logic [7:0]    text_buf[$];
    text_char_t    drive_item;
    epoch_result_t want;

    logic [PosWidth-1:0]   scan_pos;
    logic [YearWidth-1:0]  yr_digits;
    logic [FieldWidth-1:0] mo_digits;
    logic [FieldWidth-1:0] dy_digits;
    logic [FieldWidth-1:0] hr_digits;
    logic [FieldWidth-1:0] mi_digits;
    logic [FieldWidth-1:0] se_digits;
    logic                  form_ok;

    int unsigned send_gap_pct[3]   = '{23, 79, 0};
    int unsigned recv_stall_pct[3] = '{79, 23, 0};
    int unsigned phase_sel = 0;
    int unsigned total_chars = 0;
    int unsigned chars_made = 0;
    int unsigned texts_made = 0;
    int unsigned chars_sent = 0;
    int unsigned chars_taken = 0;
    int unsigned results_checked = 0;
    int unsigned valid_checked = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    string directed_texts[13] = '{
        "1970-01-01T00:00:00Z",
        "2261-12-31T23:59:59Z",
        "2000-02-29T12:34:56Z",
        "2100-02-29T00:00:00Z",
        "1969-12-31T23:59:59Z",
        "2262-01-01T00:00:00Z",
        "2023-13-00T24:60:60Z",
        "2023-04-31T10:00:00Z",
        "2020/01-01T00:00:00Z",
        "2020-01-01T00:0A:00Z",
        "Z",
        "2020-01-01T00:00:00",
        "2020-06-15T08:30:00Z0123456789ABCD"
    };

    utc_timestamp_to_epoch_seconds DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ch            (ch),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .valid_res     (valid_res),
        .epoch_seconds (epoch_seconds)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count++;

    task automatic clear_scan();
        scan_pos  = '0;
        yr_digits = '0;
        mo_digits = '0;
        dy_digits = '0;
        hr_digits = '0;
        mi_digits = '0;
        se_digits = '0;
        form_ok   = 1'b1;
    endtask

    function automatic logic [SecsWidth-1:0] civil_seconds(input int unsigned yr,
                                                           input int unsigned mo,
                                                           input int unsigned dy,
                                                           input int unsigned hr,
                                                           input int unsigned mi,
                                                           input int unsigned se);
        int unsigned       y;
        int unsigned       era;
        int unsigned       yoe;
        int unsigned       mp;
        int unsigned       doy;
        int unsigned       doe;
        longint unsigned   days;
        longint unsigned   total;
        begin
            y     = (mo <= 2) ? yr - 1 : yr;
            era   = y / EraYears;
            yoe   = y - era * EraYears;
            mp    = (mo > 2) ? mo - 3 : mo + 9;
            doy   = (153 * mp + 2) / 5 + dy - 1;
            doe   = yoe * DaysPerYear + yoe / 4 - yoe / 100 + doy;
            days  = 64'(era) * EraDays + 64'(doe) - EpochShift;
            total = days * SecsPerDay + 64'(hr) * SecsPerHour + 64'(mi) * SecsPerMin + 64'(se);
            return total[SecsWidth-1:0];
        end
    endfunction

    task automatic absorb_char(input logic [7:0] c, input logic fin);
        logic [7:0]    sep;
        int unsigned   d;
        int unsigned   dim;
        logic          leap;
        epoch_result_t res;
        begin
            case (scan_pos)
                4, 7:    sep = CharDash;
                10:      sep = CharT;
                13, 16:  sep = CharColon;
                19:      sep = CharZ;
                default: sep = CharNone;
            endcase
            if (scan_pos >= TextLen)
                form_ok = 1'b0;
            else if (sep != CharNone)
            begin
                if (c != sep)
                    form_ok = 1'b0;
            end
            else if (c < CharZero || c > CharNine)
                form_ok = 1'b0;
            else
            begin
                d = c - CharZero;
                if (scan_pos < 4)
                    yr_digits = yr_digits * 10 + d;
                else if (scan_pos < 7)
                    mo_digits = mo_digits * 10 + d;
                else if (scan_pos < 10)
                    dy_digits = dy_digits * 10 + d;
                else if (scan_pos < 13)
                    hr_digits = hr_digits * 10 + d;
                else if (scan_pos < 16)
                    mi_digits = mi_digits * 10 + d;
                else
                    se_digits = se_digits * 10 + d;
            end
            chars_taken++;
            if (!fin)
            begin
                if (scan_pos < PosMax)
                    scan_pos++;
            end
            else
            begin
                res.ok = form_ok && scan_pos == TextLen - 1
                         && yr_digits >= YearMin && yr_digits <= YearMax
                         && mo_digits >= 1 && mo_digits <= 12 && dy_digits >= 1
                         && hr_digits <= 23 && mi_digits <= 59 && se_digits <= 59;
                res.secs = '0;
                if (res.ok)
                begin
                    leap = (yr_digits % 4 == 0)
                           && ((yr_digits % 100 != 0) || (yr_digits % 400 == 0));
                    case (mo_digits)
                        2:            dim = leap ? 29 : 28;
                        4, 6, 9, 11:  dim = 30;
                        default:      dim = 31;
                    endcase
                    res.ok = dy_digits <= dim;
                end
                if (res.ok)
                    res.secs = civil_seconds(yr_digits, mo_digits, dy_digits,
                                             hr_digits, mi_digits, se_digits);
                pending_epochs = {pending_epochs, res};
                clear_scan();
            end
        end
    endtask

    task automatic load_string(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf = {text_buf, 8'(s[i])};
    endtask

    task automatic commit_text();
        text_char_t item;
        begin
            for (int i = 0; i < text_buf.size(); i++)
            begin
                item.ch   = text_buf[i];
                item.last = (i == text_buf.size() - 1);
                char_q = {char_q, item};
                chars_made++;
            end
            texts_made++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch       <= 8'h00;
            last     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_char(ch, last);
            if (!in_valid || in_ready)
            begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_gap_pct[phase_sel])
                begin
                    drive_item = char_q.pop_front();
                    in_valid  <= 1'b1;
                    ch        <= drive_item.ch;
                    last      <= drive_item.last;
                    chars_sent++;
                    phase_sel <= (chars_sent * 3) / (total_chars + 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_epochs.size() == 0)
                begin
                    $display("%0t: unexpected transaction, valid_res=%0b epoch_seconds=%0d",
                             $time, valid_res, epoch_seconds);
                    errors++;
                end
                else
                begin
                    want = pending_epochs.pop_front();
                    if (valid_res !== want.ok)
                    begin
                        $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                                 $time, want.ok, valid_res);
                        errors++;
                    end
                    if (epoch_seconds !== want.secs)
                    begin
                        $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                                 $time, want.secs, epoch_seconds);
                        errors++;
                    end
                    results_checked++;
                    if (want.ok)
                        valid_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct[phase_sel]);
        end
    end

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_epochs.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int unsigned kind;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned hr;
        int unsigned mi;
        int unsigned se;
        int unsigned r;
        int unsigned cut;

        clear_scan();
        foreach (directed_texts[i])
        begin
            load_string(directed_texts[i]);
            commit_text();
        end

        while (chars_made < TargetChars || texts_made < TargetTexts)
        begin
            kind = $urandom_range(99);
            case ($urandom_range(9))
                0:       yr = $urandom_range(9999);
                1:       yr = $urandom_range(1) ? YearMin - 1 : YearMax + 1;
                default: yr = $urandom_range(YearMin, YearMax);
            endcase
            mo = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(1, 12);
            r = $urandom_range(99);
            if (r < 70)
                dy = $urandom_range(1, 28);
            else if (r < 92)
                dy = $urandom_range(29, 31);
            else
                dy = $urandom_range(99);
            hr = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
            mi = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
            se = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
            load_string($sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", yr, mo, dy, hr, mi, se));
            if (kind >= 65 && kind < 80)
                text_buf[$urandom_range(TextLen - 1)] = $urandom_range(255);
            else if (kind >= 80 && kind < 90)
            begin
                if ($urandom_range(1))
                begin
                    cut = $urandom_range(1, TextLen - 1);
                    while (text_buf.size() > cut)
                        void'(text_buf.pop_back());
                end
                else
                    repeat ($urandom_range(1, 15))
                        text_buf = {text_buf, 8'($urandom_range(255))};
            end
            else if (kind >= 90)
            begin
                text_buf.delete();
                repeat ($urandom_range(1, 36))
                    text_buf = {text_buf, 8'($urandom_range(255))};
            end
            commit_text();
        end
        total_chars = char_q.size();

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (chars_taken == total_chars);
        wait (pending_epochs.size() == 0);
        repeat (DrainCycles) @(posedge clk);

        if (pending_epochs.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_epochs.size());
            errors++;
        end
        $display("Sent %0d timestamp texts as %0d characters; checked %0d results, %0d valid.",
                 texts_made, total_chars, results_checked, valid_checked);
        $display("Mismatches found: %0d.", errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
